FILE: hdl/binary_seq_flip_longest_nondecreasing_defines.svh
// Assertion macros for the block's control module.
`ifndef BINARY_SEQ_FLIP_LONGEST_NONDECREASING_DEFINES_SVH
`define BINARY_SEQ_FLIP_LONGEST_NONDECREASING_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define BSF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
// Antecedent implies consequent in the following cycle
`define BSF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define BSF_ASSERT(lbl, prop)
`define BSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/bsfln_pkg.sv
package bsfln_pkg;

	localparam int LEAF_BITS = 10;
	localparam int LEAVES    = 1 << LEAF_BITS;
	localparam int NODE_BITS = LEAF_BITS + 1;
	localparam int NODES     = 1 << NODE_BITS;
	localparam int CNT_W     = LEAF_BITS + 1;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_FLIP  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] up;
		logic [CNT_W-1:0] zeros;
		logic [CNT_W-1:0] ones;
		logic [CNT_W-1:0] down;
	} stats_t;

	typedef struct packed {
		logic   pending;
		stats_t stats;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_QWAIT, ST_ENTER, ST_COVER, ST_PD_CHK,
		ST_PD_L, ST_PD_R, ST_PD_P, ST_RETURN, ST_PU_RD, ST_PU_L, ST_PU_R
	} state_t;

	typedef enum logic [1:0] {ID_HOLD, ID_LEFT, ID_NEXT, ID_UP} id_op_t;
	typedef enum logic [1:0] {RA_ID, RA_LEFT, RA_RIGHT, RA_ROOT} ra_sel_t;
	typedef enum logic [1:0] {WA_ID, WA_LEFT, WA_RIGHT, WA_CLR} wa_sel_t;
	typedef enum logic [2:0] {WD_ZERO, WD_COVER, WD_INV, WD_PCLR, WD_MERGE} wd_sel_t;

	typedef struct packed {
		logic    latch;
		id_op_t  id_op;
		ra_sel_t ra_sel;
		logic    we;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		logic    hold_ld;
		logic    out_ld;
		logic    clr_inc;
	} cmd_t;

	typedef struct packed {
		logic op_ok;
		logic is_query;
		logic disjoint;
		logic covered;
		logic is_root;
		logic is_left;
		logic pending;
		logic clr_last;
	} status_t;

	function automatic logic [CNT_W-1:0] max_cnt(logic [CNT_W-1:0] x, logic [CNT_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

	function automatic stats_t combine(stats_t p, stats_t q);
		stats_t t;
		t.up    = max_cnt(p.up + q.ones, p.zeros + q.up);
		t.zeros = p.zeros + q.zeros;
		t.ones  = p.ones + q.ones;
		t.down  = max_cnt(p.down + q.zeros, p.ones + q.down);
		return t;
	endfunction

	function automatic entry_t invert(entry_t e);
		entry_t t;
		t.pending     = ~e.pending;
		t.stats.up    = e.stats.down;
		t.stats.down  = e.stats.up;
		t.stats.zeros = e.stats.ones;
		t.stats.ones  = e.stats.zeros;
		return t;
	endfunction

endpackage

FILE: hdl/bsfln_ram.sv
module bsfln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/bsfln_dp.sv
module bsfln_dp import bsfln_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              sts,
	input  logic [1:0]           opcode,
	input  logic [10:0]          range_start,
	input  logic [10:0]          range_end,
	input  logic                 symbol_is_seven,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [10:0]          seq_length,
	output logic [CNT_W-1:0]     longest_length
);

	logic [10:0]          seq_length_q;
	logic [NODE_BITS-1:0] id_q;
	logic                 op_load_q;
	logic                 seven_q;
	logic [LEAF_BITS-1:0] a0_q;
	logic [LEAF_BITS-1:0] b0_q;
	entry_t               hold_q;
	logic [NODE_BITS-1:0] clr_q;
	logic [CNT_W-1:0]     longest_q;

	logic [10:0]          len;
	logic [10:0]          start_c;
	logic [10:0]          end_c;
	logic [10:0]          a_in;
	logic [10:0]          b_in;
	logic [10:0]          a_m1;
	logic [10:0]          b_m1;
	logic                 op_ok_c;
	logic [$clog2(NODE_BITS)-1:0] depth;
	logic [NODE_BITS+LEAF_BITS-1:0] lo_wide;
	logic [LEAF_BITS-1:0] node_lo;
	logic [LEAF_BITS-1:0] node_hi;
	logic [LEAF_BITS-1:0] span_mask;
	logic [NODE_BITS-1:0] left_id;
	logic [NODE_BITS-1:0] right_id;
	logic [NODE_BITS-1:0] raddr;
	logic [NODE_BITS-1:0] waddr;
	entry_t               wdata;
	entry_t               rdata;
	entry_t               leaf;

	// configuration register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= 11'(LEAVES);
		end else if (cfg_valid) begin
			seq_length_q <= seq_length;
		end
	end

	// clamp the incoming range
	always_comb begin
		len     = (seq_length_q > 11'(LEAVES)) ? 11'(LEAVES) : seq_length_q;
		start_c = (range_start == 11'd0) ? 11'd1 : range_start;
		end_c   = (range_end > len) ? len : range_end;
		a_in    = (opcode == OP_LOAD) ? range_start : start_c;
		b_in    = (opcode == OP_LOAD) ? range_start : end_c;
		a_m1    = a_in - 11'd1;
		b_m1    = b_in - 11'd1;
		case (opcode)
			OP_LOAD: op_ok_c = (range_start != 11'd0) && (range_start <= len);
			OP_FLIP: op_ok_c = (start_c <= end_c);
			default: op_ok_c = 1'b0;
		endcase
	end

	// node span from its heap index
	always_comb begin
		depth = '0;
		for (int i = 0; i < NODE_BITS; i++) begin
			if (id_q[i]) depth = ($clog2(NODE_BITS))'(i);
		end
		lo_wide   = {id_q, LEAF_BITS'(0)} >> depth;
		node_lo   = lo_wide[LEAF_BITS-1:0];
		span_mask = {LEAF_BITS{1'b1}} >> depth;
		node_hi   = node_lo | span_mask;
		left_id   = {id_q[NODE_BITS-2:0], 1'b0};
		right_id  = {id_q[NODE_BITS-2:0], 1'b1};
		sts.is_query = (opcode == OP_QUERY);
		sts.op_ok    = op_ok_c;
		sts.disjoint = (a0_q > node_hi) || (b0_q < node_lo);
		sts.covered  = (a0_q <= node_lo) && (b0_q >= node_hi);
		sts.is_root  = (id_q == NODE_BITS'(1));
		sts.is_left  = ~id_q[0];
		sts.pending  = rdata.pending;
		sts.clr_last = (clr_q == {NODE_BITS{1'b1}});
	end

	// operation registers and node walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q  <= NODE_BITS'(1);
			clr_q <= '0;
		end else begin
			if (cmd.clr_inc) clr_q <= clr_q + NODE_BITS'(1);
			if (cmd.latch) begin
				id_q <= NODE_BITS'(1);
			end else begin
				case (cmd.id_op)
					ID_LEFT: id_q <= left_id;
					ID_NEXT: id_q <= id_q + NODE_BITS'(1);
					ID_UP:   id_q <= id_q >> 1;
					default: id_q <= id_q;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_load_q <= (opcode == OP_LOAD);
			seven_q   <= symbol_is_seven;
			a0_q      <= a_m1[LEAF_BITS-1:0];
			b0_q      <= b_m1[LEAF_BITS-1:0];
		end
		if (cmd.hold_ld) hold_q <= rdata;
		if (cmd.out_ld) longest_q <= rdata.stats.up;
	end

	// memory address and write data selection
	always_comb begin
		leaf.pending     = 1'b0;
		leaf.stats.up    = CNT_W'(1);
		leaf.stats.down  = CNT_W'(1);
		leaf.stats.zeros = {{(CNT_W-1){1'b0}}, ~seven_q};
		leaf.stats.ones  = {{(CNT_W-1){1'b0}}, seven_q};
		case (cmd.ra_sel)
			RA_LEFT:  raddr = left_id;
			RA_RIGHT: raddr = right_id;
			RA_ROOT:  raddr = NODE_BITS'(1);
			default:  raddr = id_q;
		endcase
		case (cmd.wa_sel)
			WA_LEFT:  waddr = left_id;
			WA_RIGHT: waddr = right_id;
			WA_CLR:   waddr = clr_q;
			default:  waddr = id_q;
		endcase
		case (cmd.wd_sel)
			WD_COVER: wdata = op_load_q ? leaf : invert(rdata);
			WD_INV:   wdata = invert(rdata);
			WD_PCLR:  wdata = {1'b0, hold_q.stats};
			WD_MERGE: wdata = {1'b0, combine(hold_q.stats, rdata.stats)};
			default:  wdata = '0;
		endcase
	end

	bsfln_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NODES)
	) u_tree (
		.clk  (clk),
		.we   (cmd.we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign longest_length = longest_q;

endmodule

FILE: hdl/bsfln_ctrl.sv
`include "binary_seq_flip_longest_nondecreasing_defines.svh"
module bsfln_ctrl import bsfln_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t sts,
	output cmd_t    cmd,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept && sts.is_query) state_d = ST_QWAIT;
				else if (accept && sts.op_ok) state_d = ST_ENTER;
			end
			ST_QWAIT:  if (out_free) state_d = ST_IDLE;
			ST_ENTER: begin
				if (sts.disjoint) state_d = ST_RETURN;
				else if (sts.covered) state_d = ST_COVER;
				else state_d = ST_PD_CHK;
			end
			ST_COVER:  state_d = ST_RETURN;
			ST_PD_CHK: state_d = sts.pending ? ST_PD_L : ST_ENTER;
			ST_PD_L:   state_d = ST_PD_R;
			ST_PD_R:   state_d = ST_PD_P;
			ST_PD_P:   state_d = ST_ENTER;
			ST_RETURN: begin
				if (sts.is_root) state_d = ST_IDLE;
				else if (sts.is_left) state_d = ST_ENTER;
				else state_d = ST_PU_RD;
			end
			ST_PU_RD:  state_d = ST_PU_L;
			ST_PU_L:   state_d = ST_PU_R;
			ST_PU_R:   state_d = ST_RETURN;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.latch   = 1'b0;
		cmd.id_op   = ID_HOLD;
		cmd.ra_sel  = RA_ID;
		cmd.we      = 1'b0;
		cmd.wa_sel  = WA_ID;
		cmd.wd_sel  = WD_ZERO;
		cmd.hold_ld = 1'b0;
		cmd.out_ld  = 1'b0;
		cmd.clr_inc = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.we      = 1'b1;
				cmd.wa_sel  = WA_CLR;
				cmd.clr_inc = 1'b1;
			end
			ST_IDLE: begin
				cmd.latch  = accept;
				cmd.ra_sel = RA_ROOT;
			end
			ST_QWAIT: begin
				cmd.ra_sel = RA_ROOT;
				cmd.out_ld = out_free;
			end
			ST_ENTER:  cmd.ra_sel = RA_ID;
			ST_COVER: begin
				cmd.we     = 1'b1;
				cmd.wd_sel = WD_COVER;
			end
			ST_PD_CHK: begin
				cmd.hold_ld = 1'b1;
				cmd.ra_sel  = RA_LEFT;
				if (!sts.pending) cmd.id_op = ID_LEFT;
			end
			ST_PD_L: begin
				cmd.we     = 1'b1;
				cmd.wa_sel = WA_LEFT;
				cmd.wd_sel = WD_INV;
				cmd.ra_sel = RA_RIGHT;
			end
			ST_PD_R: begin
				cmd.we     = 1'b1;
				cmd.wa_sel = WA_RIGHT;
				cmd.wd_sel = WD_INV;
			end
			ST_PD_P: begin
				cmd.we     = 1'b1;
				cmd.wd_sel = WD_PCLR;
				cmd.id_op  = ID_LEFT;
			end
			ST_RETURN: begin
				if (!sts.is_root) cmd.id_op = sts.is_left ? ID_NEXT : ID_UP;
			end
			ST_PU_RD:  cmd.ra_sel = RA_LEFT;
			ST_PU_L: begin
				cmd.hold_ld = 1'b1;
				cmd.ra_sel  = RA_RIGHT;
			end
			ST_PU_R: begin
				cmd.we     = 1'b1;
				cmd.wd_sel = WD_MERGE;
			end
			default: cmd.latch = 1'b0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	`BSF_ASSERT_NEXT(a_query_waits, accept && sts.is_query, state_q == ST_QWAIT)
	`BSF_ASSERT(a_result_from_query, $rose(out_valid_q) |-> $past(state_q) == ST_QWAIT)
	`BSF_ASSERT(a_no_result_in_clear, state_q == ST_CLEAR |-> !out_valid_q)
	`BSF_ASSERT_NEXT(a_pushdown_order, state_q == ST_PD_L, state_q == ST_PD_R)

endmodule

FILE: hdl/binary_seq_flip_longest_nondecreasing.sv
// Binary sequence of 1024 symbols kept in a segment tree with lazy flip marks, held in one
// 2048 x 45 bit memory with one read and one write port. After reset a clearing pass writes
// every node to zero with in_stall high; seq_length writes are taken at any time. A query
// waits until the output register is free, then loads the root's result into it. A load
// walks one root-to-leaf path and pull-up path. A flip visits up to about four nodes per
// level; each visited node is served through the one read port (push-down and pull-up are
// read-modify-write sequences). One item is in work at a time; the query result sits in an
// output register.
module binary_seq_flip_longest_nondecreasing import bsfln_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [10:0] range_start,
	input  logic [10:0] range_end,
	input  logic        symbol_is_seven,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] longest_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] seq_length
);

	cmd_t    cmd;
	status_t sts;

	bsfln_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	bsfln_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.range_start    (range_start),
		.range_end      (range_end),
		.symbol_is_seven(symbol_is_seven),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.seq_length     (seq_length),
		.longest_length (longest_length)
	);

endmodule
